// ----- rtl/ovs_uart_pkg.sv -----
// shared types and constants for the oversampled 8n1 uart transceiver
// no dependencies
package ovs_uart_pkg;

  localparam int unsigned CfgW       = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CntW       = 8;
  localparam int unsigned BitsW      = 4;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;

  localparam logic [CfgW-1:0]  TicksPerBitRst = 8'd3;
  localparam logic [CfgW-1:0]  FirstDelayRst  = 8'd4;
  localparam logic [BitsW-1:0] FrameBits      = 4'd9;

  typedef enum logic [0:0] {
    CfgTicksPerBit      = 1'b0,
    CfgFirstSampleDelay = 1'b1
  } cfg_idx_e;

endpackage

// ----- rtl/oversampled_uart_rx_tx_unit.sv -----
// oversampled 8n1 uart receiver and transmitter, one tick per input item
// depends on ovs_uart_pkg
// an accepted item's result is registered into the output register at the edge that accepts it
// throughput: one item per cycle; the next item is taken while a result waits
// when the downstream side is ready in the same cycle
// reset: asynchronous active low; counters cleared, tx line high, tx idle set,
// registers back to ticks_per_bit 3 and first_sample_delay 4
module oversampled_uart_rx_tx_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  ovs_uart_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [ovs_uart_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // rx_level, tx_load, tx_byte[7:0], zero fill
  input  logic [ovs_uart_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tx_line, rx_done, rx_byte[7:0], tx_idle, zero fill
  output logic [ovs_uart_pkg::OutDataW-1:0]   m_axis_tdata
);
  import ovs_uart_pkg::*;

  logic [CfgW-1:0]     tpb_q, fsd_q;
  logic                rx_active_q, rx_active_d;
  logic [CntW-1:0]     rx_cnt_q, rx_cnt_d;
  logic [BitsW-1:0]    rx_left_q, rx_left_d;
  logic [ByteW-1:0]    rx_shift_q, rx_shift_d;
  logic [ByteW-1:0]    rx_hold_q, rx_hold_d;
  logic                tx_active_q, tx_active_d;
  logic [CntW-1:0]     tx_cnt_q, tx_cnt_d;
  logic [BitsW-1:0]    tx_left_q, tx_left_d;
  logic [ByteW-1:0]    tx_shift_q, tx_shift_d;
  logic [ByteW-1:0]    tx_hold_q, tx_hold_d;
  logic                tx_level_q, tx_level_d;
  logic                tx_idle_q, tx_idle_d;
  logic                rx_done;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                accept;

  logic                in_level, in_load;
  logic [ByteW-1:0]    in_byte;

  assign in_level = s_axis_tdata[0];
  assign in_load  = s_axis_tdata[1];
  assign in_byte  = s_axis_tdata[ByteW+1:2];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= TicksPerBitRst;
      fsd_q <= FirstDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTicksPerBit:      tpb_q <= cfg_data_i;
        CfgFirstSampleDelay: fsd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CntW-1:0] rx_dec, tx_dec;
    logic [BitsW-1:0] left_dec;
    rx_active_d = rx_active_q;
    rx_cnt_d    = rx_cnt_q;
    rx_left_d   = rx_left_q;
    rx_shift_d  = rx_shift_q;
    rx_hold_d   = rx_hold_q;
    tx_active_d = tx_active_q;
    tx_left_d   = tx_left_q;
    tx_shift_d  = tx_shift_q;
    tx_hold_d   = tx_hold_q;
    tx_level_d  = tx_level_q;
    tx_idle_d   = tx_idle_q;
    rx_done     = 1'b0;

    // load only while idle
    if (in_load && tx_idle_q) begin
      tx_idle_d   = 1'b0;
      tx_hold_d   = in_byte;
      tx_active_d = 1'b1;
    end

    // receiver
    rx_dec = rx_cnt_q - 1'b1;
    if (rx_active_q) begin
      rx_cnt_d = rx_dec;
      if (rx_dec == '0) begin
        rx_cnt_d  = tpb_q;
        rx_left_d = rx_left_q - 1'b1;
        if (rx_left_d == '0) begin
          rx_hold_d   = rx_shift_q;
          rx_active_d = 1'b0;
          rx_done     = 1'b1;
        end else begin
          rx_shift_d = {in_level, rx_shift_q[ByteW-1:1]};
        end
      end
    end else if (!in_level) begin
      rx_active_d = 1'b1;
      rx_cnt_d    = fsd_q;
      rx_left_d   = FrameBits;
    end

    // transmitter, free-running bit clock
    tx_dec   = tx_cnt_q - 1'b1;
    tx_cnt_d = tx_dec;
    left_dec = tx_left_q - 1'b1;
    if (tx_dec == '0) begin
      tx_cnt_d = tpb_q;
      if (tx_active_d) begin
        if (tx_left_q == '0) begin
          tx_level_d = 1'b0;
          tx_shift_d = tx_hold_d;
          tx_left_d  = FrameBits;
        end else begin
          tx_shift_d = {1'b0, tx_shift_q[ByteW-1:1]};
          tx_left_d  = left_dec;
          if (left_dec == '0) begin
            tx_level_d  = 1'b1;
            tx_active_d = 1'b0;
            tx_idle_d   = 1'b1;
          end else begin
            tx_level_d = tx_shift_q[0];
          end
        end
      end
    end

    out_data_d = {{(OutDataW-ByteW-3){1'b0}}, tx_idle_d, rx_hold_d, rx_done, tx_level_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_active_q <= 1'b0;
      rx_cnt_q    <= '0;
      rx_left_q   <= '0;
      rx_shift_q  <= '0;
      rx_hold_q   <= '0;
      tx_active_q <= 1'b0;
      tx_cnt_q    <= '0;
      tx_left_q   <= '0;
      tx_shift_q  <= '0;
      tx_hold_q   <= '0;
      tx_level_q  <= 1'b1;
      tx_idle_q   <= 1'b1;
    end else if (accept) begin
      rx_active_q <= rx_active_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_left_q   <= rx_left_d;
      rx_shift_q  <= rx_shift_d;
      rx_hold_q   <= rx_hold_d;
      tx_active_q <= tx_active_d;
      tx_cnt_q    <= tx_cnt_d;
      tx_left_q   <= tx_left_d;
      tx_shift_q  <= tx_shift_d;
      tx_hold_q   <= tx_hold_d;
      tx_level_q  <= tx_level_d;
      tx_idle_q   <= tx_idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ----- verif/testbench.sv -----
// testbench for oversampled_uart_rx_tx_unit: one oversampling tick per stream item
// checks each result against a uart model kept in this file, or against the table's expected value for known rows
// depends on ovs_uart_pkg and the unit's rtl
`timescale 1ns / 1ps

module testbench;
  import ovs_uart_pkg::*;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_load;
    logic       rx_level;
  } uart_in_t;

  typedef struct packed {
    logic       tx_idle;
    logic [7:0] rx_byte;
    logic       rx_done;
    logic       tx_line;
  } uart_out_t;

  typedef struct {
    logic       rx_level;
    logic       tx_load;
    logic [7:0] tx_byte;
    int         reps;
    bit         known;
    uart_out_t  want;
  } tick_row_t;

  localparam int NumPhases   = 6;
  localparam int StallLimit  = 4000;
  localparam uart_out_t ResetOut = '{tx_idle: 1'b1, rx_byte: 8'h00, rx_done: 1'b0,
                                     tx_line: 1'b1};
  localparam uart_out_t BusyOut  = '{tx_idle: 1'b0, rx_byte: 8'h00, rx_done: 1'b0,
                                     tx_line: 1'b1};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  cfg_idx_e            cfg_idx = CfgTicksPerBit;
  logic [CfgW-1:0]     cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  oversampled_uart_rx_tx_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // uart model state
  logic [7:0] bit_ticks   = TicksPerBitRst;
  logic [7:0] first_delay = FirstDelayRst;
  logic       rx_busy  = 1'b0;
  logic [7:0] rx_cnt   = '0;
  logic [3:0] rx_left  = '0;
  logic [7:0] rx_sreg  = '0;
  logic [7:0] rx_last  = '0;
  logic       tx_busy  = 1'b0;
  logic [7:0] tx_cnt   = '0;
  logic [3:0] tx_left  = '0;
  logic [7:0] tx_sreg  = '0;
  logic [7:0] tx_pend  = '0;
  logic       tx_lvl   = 1'b1;
  logic       tx_free  = 1'b1;

  uart_out_t  line_results_q[$];
  logic       rx_wave_q[$];
  int         send_gap_pct = 0;
  int         stall_pct = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;

  function automatic uart_out_t uart_tick(uart_in_t it);
    logic       done;
    logic       tbit;
    uart_out_t  res;
    done = 1'b0;
    if (it.tx_load && tx_free) begin
      tx_free = 1'b0;
      tx_pend = it.tx_byte;
      tx_busy = 1'b1;
    end
    if (rx_busy) begin
      rx_cnt = rx_cnt - 8'd1;
      if (rx_cnt == 8'd0) begin
        rx_cnt  = bit_ticks;
        rx_left = rx_left - 4'd1;
        if (rx_left == 4'd0) begin
          rx_last = rx_sreg;
          rx_busy = 1'b0;
          done    = 1'b1;
        end else begin
          rx_sreg = {it.rx_level, rx_sreg[7:1]};
        end
      end
    end else if (!it.rx_level) begin
      rx_busy = 1'b1;
      rx_cnt  = first_delay;
      rx_left = FrameBits;
    end
    tx_cnt = tx_cnt - 8'd1;
    if (tx_cnt == 8'd0) begin
      tx_cnt = bit_ticks;
      if (tx_busy) begin
        if (tx_left == 4'd0) begin
          tx_lvl  = 1'b0;
          tx_sreg = tx_pend;
          tx_left = FrameBits;
        end else begin
          tbit    = tx_sreg[0];
          tx_sreg = tx_sreg >> 1;
          tx_left = tx_left - 4'd1;
          if (tx_left == 4'd0) begin
            tx_lvl  = 1'b1;
            tx_busy = 1'b0;
            tx_free = 1'b1;
          end else begin
            tx_lvl = tbit;
          end
        end
      end
    end
    res.tx_line = tx_lvl;
    res.rx_done = done;
    res.rx_byte = rx_last;
    res.tx_idle = tx_free;
    return res;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgTicksPerBit) bit_ticks = val;
    else first_delay = val;
  endtask

  task automatic send_tick(uart_in_t it, bit known, uart_out_t want);
    uart_out_t res;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(InDataW - $bits(uart_in_t)){1'b0}}, it};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    res = uart_tick(it);
    line_results_q.push_back(known ? want : res);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // well-formed frame at the current bit rate, sometimes with a glitch
  task automatic queue_rx_frame();
    int   tpb;
    int   base;
    logic [7:0] val;
    tpb  = (bit_ticks == 8'd0) ? 256 : bit_ticks;
    base = rx_wave_q.size();
    val  = 8'($urandom_range(255));
    repeat (tpb) rx_wave_q.push_back(1'b0);
    for (int b = 0; b < 8; b++) repeat (tpb) rx_wave_q.push_back(val[b]);
    repeat (tpb + $urandom_range(tpb)) rx_wave_q.push_back(1'b1);
    if ($urandom_range(7) == 0) begin
      int pos;
      pos = base + $urandom_range(rx_wave_q.size() - base - 1);
      rx_wave_q[pos] = ~rx_wave_q[pos];
    end
  endtask

  always @(posedge clk_i) begin
    m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    uart_out_t got;
    uart_out_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data[$bits(uart_out_t)-1:0];
      if (line_results_q.size() == 0) begin
        $error("result with nothing expected: %h", m_data);
        fail_count++;
      end else begin
        want = line_results_q.pop_front();
        if (got.tx_line !== want.tx_line) begin
          $error("tx_line expected %0d got %0d", want.tx_line, got.tx_line);
          fail_count++;
        end
        if (got.rx_done !== want.rx_done) begin
          $error("rx_done expected %0d got %0d", want.rx_done, got.rx_done);
          fail_count++;
        end
        if (got.rx_byte !== want.rx_byte) begin
          $error("rx_byte expected %h got %h", want.rx_byte, got.rx_byte);
          fail_count++;
        end
        if (got.tx_idle !== want.tx_idle) begin
          $error("tx_idle expected %0d got %0d", want.tx_idle, got.tx_idle);
          fail_count++;
        end
      end
    end
  end

  // ends the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    tick_row_t  rows[$];
    uart_in_t   it;
    int         ph_tpb[NumPhases];
    int         ph_fsd[NumPhases];
    int         ph_items[NumPhases];
    // tx frame in flight; a load while busy is dropped; 0x00 and 0xff received
    rows = '{
      '{1'b1, 1'b0, 8'h00, 1, 1'b1, ResetOut},
      '{1'b1, 1'b1, 8'hff, 1, 1'b1, BusyOut},
      '{1'b1, 1'b1, 8'h00, 1, 1'b1, BusyOut},
      '{1'b0, 1'b0, 8'h00, 9, 1'b0, ResetOut},
      '{1'b1, 1'b0, 8'h00, 1, 1'b0, ResetOut},
      '{1'b0, 1'b0, 8'h00, 1, 1'b0, ResetOut},
      '{1'b1, 1'b0, 8'h00, 9, 1'b0, ResetOut},
      '{1'b1, 1'b1, 8'h5a, 1, 1'b0, ResetOut}
    };
    ph_tpb   = '{3, 2, 255, 8, $urandom_range(2, 255), 1};
    ph_fsd   = '{4, 1, 255, 12, $urandom_range(1, 255), 0};
    ph_items = '{180, 160, 220, 140, 130, 96};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // one tick per bit is the tightest setting
    write_reg(CfgTicksPerBit, 8'd1);
    write_reg(CfgFirstSampleDelay, 8'd1);

    foreach (rows[r]) begin
      for (int k = 0; k < rows[r].reps; k++) begin
        it.rx_level = rows[r].rx_level;
        it.tx_load  = rows[r].tx_load;
        it.tx_byte  = rows[r].tx_byte;
        send_tick(it, rows[r].known, rows[r].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(CfgTicksPerBit, 8'(ph_tpb[p]));
      write_reg(CfgFirstSampleDelay, 8'(ph_fsd[p]));
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 8; stall_pct = 8; end
      endcase
      rx_wave_q.delete();
      for (int n = 0; n < ph_items[p]; n++) begin
        if (rx_wave_q.size() == 0) begin
          if ($urandom_range(4) != 0) begin
            queue_rx_frame();
          end else begin
            repeat ($urandom_range(1, 6)) rx_wave_q.push_back(1'($urandom_range(1)));
          end
        end
        it.rx_level = rx_wave_q.pop_front();
        it.tx_load  = ($urandom_range(5) == 0);
        it.tx_byte  = 8'($urandom_range(255));
        send_tick(it, 1'b0, ResetOut);
      end
    end

    send_gap_pct = 0;
    stall_pct = 0;
    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ovs_uart_pkg.sv
rtl/oversampled_uart_rx_tx_unit.sv
verif/testbench.sv
